>>> hdl/hla_pkg.sv
// Shared types and constants for the hole list allocator.
// Used by hla_cell, hla_ctrl and hole_list_allocator; no dependencies.
package hla_pkg;

	localparam int MaxHoles = 32;
	localparam int AddrWidth = 16;
	localparam int IdxWidth = $clog2(MaxHoles);
	localparam int CntWidth = $clog2(MaxHoles + 1);
	localparam int PoolReset = 1024;

	localparam logic [1:0] PolicyFirst = 2'd0;
	localparam logic [1:0] PolicyBest = 2'd1;
	localparam logic [1:0] PolicyWorst = 2'd2;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusNoFit = 2'd1;
	localparam logic [1:0] StatusFull = 2'd2;

	localparam logic CfgPolicy = 1'b0;
	localparam logic CfgPool = 1'b1;

	typedef logic [AddrWidth-1:0] addr_t;

	typedef struct packed {
		addr_t top;
		addr_t size;
	} hole_t;

	// Command broadcast to every cell.
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INIT,
		CMD_CARVE,
		CMD_REMOVE,
		CMD_INSERT,
		CMD_MERGE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic [IdxWidth-1:0] idx;
		hole_t hole;
		addr_t amount;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_INS,
		ST_MERGE,
		ST_SUM,
		ST_DONE
	} state_t;

endpackage

>>> hdl/hole_list_allocator.sv
// Top level of the hole list allocator: row of hole cells plus the sequencer.
// Depends on hla_pkg, hla_cell, hla_ctrl.
//
// channel | direction | request contents
// s_axis  | in        | tdata: func, req_size, block_top
// m_axis  | out       | tdata: status, alloc_top, hole_count, free_total
// cfg     | in        | cfg_addr register index, cfg_data value
//
// An allocate runs a scan over the cell row, the carve and a summing walk. A free
// runs a scan, the insert, a merge walk and a summing walk. Reset loads one hole
// covering 1024 units; a pool write reloads the table the next cycle, with
// s_axis_tready low for that cycle. One request is in flight at a time; the result
// is held until m_axis_tready, and s_axis_tready is low meanwhile.
module hole_list_allocator (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // func[0], req_size[16:1], block_top[32:17]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // status[1:0], alloc_top[17:2], hole_count[23:18], free_total[39:24]
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_addr,
	input logic [15:0] cfg_data
);
	import hla_pkg::*;

	logic [1:0] policy_q;
	addr_t pool_q;
	logic init_pend_q;
	logic start, busy;
	cell_ctl_t ctl;
	hole_t tab [MaxHoles];
	hole_t init_hole;
	logic [1:0] r_status;
	addr_t r_top, r_total;
	logic [CntWidth-1:0] r_count;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy && !init_pend_q;
	assign start = s_axis_tvalid && s_axis_tready;

	// Configuration registers; the pool table reloads the cycle after a pool write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= PolicyFirst;
			pool_q <= addr_t'(PoolReset);
			init_pend_q <= 1'b1;
		end else begin
			init_pend_q <= cfg_valid && cfg_addr == CfgPool;
			if (cfg_valid && cfg_addr == CfgPolicy) policy_q <= cfg_data[1:0];
			if (cfg_valid && cfg_addr == CfgPool) pool_q <= cfg_data;
		end
	end

	generate
		for (genvar g = 0; g < MaxHoles; g++) begin : g_cell
			hole_t prev_h, next_h;
			if (g == 0) begin : g_first
				assign prev_h = '0;
				assign init_hole = '{top: pool_q, size: pool_q};
			end else begin : g_mid
				assign prev_h = tab[g-1];
			end
			if (g == MaxHoles - 1) begin : g_last
				assign next_h = '0;
			end else begin : g_nl
				assign next_h = tab[g+1];
			end
			hla_cell u_cell (
				.clk(clk),
				.my_idx(IdxWidth'(g)),
				.ctl(ctl),
				.init_hole(g == 0 ? init_hole : '0),
				.from_prev(prev_h),
				.from_next(next_h),
				.hole(tab[g])
			);
		end
	endgenerate

	hla_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(s_axis_tdata[0]),
		.req_size(s_axis_tdata[16:1]),
		.block_top(s_axis_tdata[32:17]),
		.fit_policy(policy_q),
		.cfg_init(init_pend_q),
		.pool_empty(pool_q == '0),
		.tab(tab),
		.res_taken(m_axis_tready),
		.ctl(ctl),
		.busy(busy),
		.res_valid(m_axis_tvalid),
		.res_status(r_status),
		.res_top(r_top),
		.res_count(r_count),
		.res_total(r_total)
	);

	assign m_axis_tdata = {r_total, r_count, r_top, r_status};
endmodule

>>> hdl/hla_cell.sv
// One table slot of the hole list allocator: holds one hole, shifts with its neighbors.
// Depends on hla_pkg.
module hla_cell (
	input logic clk,
	input logic [hla_pkg::IdxWidth-1:0] my_idx,
	input hla_pkg::cell_ctl_t ctl,
	input hla_pkg::hole_t init_hole,
	input hla_pkg::hole_t from_prev,
	input hla_pkg::hole_t from_next,
	output hla_pkg::hole_t hole
);
	import hla_pkg::*;

	hole_t hole_q;
	logic [AddrWidth:0] msum;

	assign hole = hole_q;
	assign msum = {1'b0, hole_q.size} + {1'b0, from_next.size};

	// Slot update: load on init, local edit at idx, shift up above idx, shift down past idx
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INIT: hole_q <= init_hole;
			CMD_CARVE: if (my_idx == ctl.idx) begin
				hole_q.top <= hole_q.top - ctl.amount;
				hole_q.size <= hole_q.size - ctl.amount;
			end
			CMD_REMOVE: if (my_idx >= ctl.idx) begin
				hole_q <= from_next;
			end
			CMD_INSERT: if (my_idx == ctl.idx) begin
				hole_q <= ctl.hole;
			end else if (my_idx > ctl.idx) begin
				hole_q <= from_prev;
			end
			CMD_MERGE: if (my_idx == ctl.idx) begin
				hole_q.size <= msum[AddrWidth] ? '1 : msum[AddrWidth-1:0];
			end else if (my_idx > ctl.idx) begin
				hole_q <= from_next;
			end
			default: ;
		endcase
	end
endmodule

>>> hdl/hla_ctrl.sv
// Sequencer for the hole list allocator: scans, edits and sums over the cell row.
// Depends on hla_pkg.
module hla_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic func,
	input hla_pkg::addr_t req_size,
	input hla_pkg::addr_t block_top,
	input logic [1:0] fit_policy,
	input logic cfg_init,
	input logic pool_empty,
	input hla_pkg::hole_t tab [hla_pkg::MaxHoles],
	input logic res_taken,
	output hla_pkg::cell_ctl_t ctl,
	output logic busy,
	output logic res_valid,
	output logic [1:0] res_status,
	output hla_pkg::addr_t res_top,
	output logic [hla_pkg::CntWidth-1:0] res_count,
	output hla_pkg::addr_t res_total
);
	import hla_pkg::*;

	state_t state_q, state_d;
	logic [CntWidth-1:0] used_q;
	logic [CntWidth-1:0] ptr_q;
	logic func_q;
	addr_t req_q, btop_q;
	logic found_q, done_scan_q;
	logic [IdxWidth-1:0] pick_q;
	addr_t pick_size_q;
	logic [1:0] status_q;
	addr_t atop_q;
	logic [AddrWidth:0] total_q;
	logic valid_q;

	logic [IdxWidth-1:0] pidx;
	hole_t cur, nxt;
	logic in_range, fits, better;
	addr_t bottom;
	logic [AddrWidth+1:0] tsum;

	assign pidx = ptr_q[IdxWidth-1:0];
	assign in_range = ptr_q < used_q;
	assign cur = tab[pidx];
	assign nxt = tab[(pidx == IdxWidth'(MaxHoles - 1)) ? pidx : pidx + 1'b1];
	assign fits = cur.size >= req_q;
	assign better = !found_q
		|| (fit_policy == PolicyBest && cur.size < pick_size_q)
		|| (fit_policy == PolicyWorst && cur.size > pick_size_q);
	assign bottom = cur.top - cur.size;
	assign tsum = {1'b0, total_q} + {2'b0, cur.size};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) begin
				state_d = ST_SCAN;
			end
			ST_SCAN: if (!in_range || done_scan_q
					|| (!func_q && fits && fit_policy == PolicyFirst)
					|| (func_q && !(btop_q < cur.top))) begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (!func_q || req_q == '0 || used_q >= CntWidth'(MaxHoles)) state_d = ST_SUM;
				else state_d = ST_INS;
			end
			ST_INS: state_d = ST_MERGE;
			ST_MERGE: if (ptr_q + 1'b1 >= used_q) begin
				state_d = ST_SUM;
			end
			ST_SUM: if (!in_range) begin
				state_d = ST_DONE;
			end
			ST_DONE: if (!valid_q || res_taken) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Cell commands
	always_comb begin
		ctl.cmd = CMD_HOLD;
		ctl.idx = pidx;
		ctl.hole = '{top: btop_q, size: req_q};
		ctl.amount = req_q;
		unique case (state_q)
			ST_APPLY: if (!func_q && found_q && fit_policy <= PolicyWorst) begin
				ctl.idx = pick_q;
				ctl.cmd = CMD_CARVE;
			end
			ST_INS: ctl.cmd = CMD_INSERT;
			ST_MERGE: if (ptr_q + 1'b1 < used_q && bottom == nxt.top) begin
				ctl.cmd = CMD_MERGE;
			end
			default: ;
		endcase
		if (cfg_init) ctl.cmd = CMD_INIT;
		// Empty hole left by a carve is removed on entry to ST_SUM
		if (state_q == ST_SUM && ptr_q == '0 && !func_q && found_q && req_q != '0
				&& tab[pick_q].size == '0 && status_q == StatusOk && !done_scan_q) begin
			ctl.idx = pick_q;
			ctl.cmd = CMD_REMOVE;
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= CntWidth'(1);
			valid_q <= 1'b0;
			ptr_q <= '0;
			func_q <= 1'b0;
			req_q <= '0;
			btop_q <= '0;
			found_q <= 1'b0;
			done_scan_q <= 1'b0;
			pick_q <= '0;
			pick_size_q <= '0;
			status_q <= StatusOk;
			atop_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_init) used_q <= pool_empty ? '0 : CntWidth'(1);
			unique case (state_q)
				ST_IDLE: if (start) begin
					func_q <= func;
					req_q <= req_size;
					btop_q <= block_top;
					ptr_q <= '0;
					found_q <= 1'b0;
					done_scan_q <= 1'b0;
					pick_q <= '0;
					pick_size_q <= '0;
				end
				ST_SCAN: begin
					if (!func_q && in_range && fits && better) begin
						found_q <= 1'b1;
						pick_q <= pidx;
						pick_size_q <= cur.size;
					end
					if (state_d == ST_SCAN) ptr_q <= ptr_q + 1'b1;
				end
				ST_APPLY: begin
					status_q <= StatusOk;
					atop_q <= '0;
					if (!func_q) begin
						if (found_q && fit_policy <= PolicyWorst) atop_q <= tab[pick_q].top;
						else status_q <= StatusNoFit;
					end else if (req_q != '0 && used_q >= CntWidth'(MaxHoles)) begin
						status_q <= StatusFull;
					end
					if (state_d == ST_SUM) ptr_q <= '0;
					total_q <= '0;
				end
				ST_INS: begin
					used_q <= used_q + 1'b1;
					ptr_q <= '0;
				end
				ST_MERGE: begin
					if (state_d == ST_SUM) ptr_q <= '0;
					else if (ctl.cmd == CMD_MERGE) used_q <= used_q - 1'b1;
					else ptr_q <= ptr_q + 1'b1;
				end
				ST_SUM: begin
					if (ctl.cmd == CMD_REMOVE) begin
						used_q <= used_q - 1'b1;
						done_scan_q <= 1'b1;
					end else if (in_range) begin
						total_q <= tsum[AddrWidth+1:AddrWidth] != '0 ? {1'b0, 16'hFFFF}
							: tsum[AddrWidth:0];
						ptr_q <= ptr_q + 1'b1;
					end
					if (state_d == ST_DONE) valid_q <= 1'b1;
				end
				ST_DONE: if (res_taken) begin
					valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign res_valid = valid_q;
	assign res_status = status_q;
	assign res_top = atop_q;
	assign res_count = used_q;
	assign res_total = total_q[AddrWidth-1:0];
endmodule

>>> hdl/hla_checker.sv
// Port-level checks for the hole list allocator, bound to the top level.
// Depends on hole_list_allocator ports only.
module hla_port_props (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	// no new request while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept during result");
	// hole count never exceeds the table
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:18] <= 6'd32) else $error("count range");
	// status code valid
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
	// result stays while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
endmodule

bind hole_list_allocator hla_port_props u_hla_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

>>> sim/hla_checker.sv
// Checker for the hole list allocator: watches the request, result and register
// channels, keeps its own copy of the hole table and compares each result.
// Depends on hla_pkg.
module hla_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [39:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic cfg_addr,
	input logic [15:0] cfg_data,
	output int fails,
	output int pending
);
	import hla_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] alloc_top;
		logic [5:0] hole_count;
		logic [15:0] free_total;
	} alloc_result_t;

	logic [1:0] policy;
	logic [15:0] pool;
	logic [15:0] tops [MaxHoles];
	logic [15:0] sizes [MaxHoles];
	int used;
	alloc_result_t result_q[$];

	// Rebuild the table as one hole over the whole pool
	function automatic void load_pool();
		for (int k = 0; k < MaxHoles; k++) begin
			tops[k] = '0;
			sizes[k] = '0;
		end
		used = 0;
		if (pool != 0) begin
			tops[0] = pool;
			sizes[0] = pool;
			used = 1;
		end
	endfunction

	function automatic void drop_hole(int idx);
		for (int k = idx; k + 1 < used; k++) begin
			tops[k] = tops[k+1];
			sizes[k] = sizes[k+1];
		end
		if (used > 0) begin
			used--;
			tops[used] = '0;
			sizes[used] = '0;
		end
	endfunction

	// One pass down the table joining holes that touch
	function automatic void join_holes();
		int i;
		logic [15:0] bottom;
		logic [16:0] sum;
		i = 0;
		while (i + 1 < used) begin
			bottom = tops[i] - sizes[i];
			if (bottom == tops[i+1]) begin
				sum = {1'b0, sizes[i]} + {1'b0, sizes[i+1]};
				sizes[i] = sum[16] ? 16'hFFFF : sum[15:0];
				drop_hole(i + 1);
			end else begin
				i++;
			end
		end
	endfunction

	function automatic alloc_result_t serve(logic func, logic [15:0] req, logic [15:0] btop);
		alloc_result_t r;
		int pick;
		int pos;
		logic [16:0] total;
		r = '0;
		pick = -1;
		if (func == 1'b0) begin
			// pick a hole by the current policy; earliest wins on a tie
			for (int i = 0; i < used; i++) begin
				if (sizes[i] >= req) begin
					if (policy == PolicyFirst) begin
						if (pick < 0) pick = i;
					end else if (policy == PolicyBest) begin
						if (pick < 0 || sizes[i] < sizes[pick]) pick = i;
					end else if (policy == PolicyWorst) begin
						if (pick < 0 || sizes[i] > sizes[pick]) pick = i;
					end
				end
			end
			if (pick >= 0) begin
				r.alloc_top = tops[pick];
				tops[pick] = tops[pick] - req;
				sizes[pick] = sizes[pick] - req;
				if (sizes[pick] == 0 && req != 0) drop_hole(pick);
			end else begin
				r.status = StatusNoFit;
			end
		end else if (req != 0) begin
			if (used >= MaxHoles) begin
				r.status = StatusFull;
			end else begin
				pos = 0;
				while (pos < used && btop < tops[pos]) pos++;
				for (int i = used; i > pos; i--) begin
					tops[i] = tops[i-1];
					sizes[i] = sizes[i-1];
				end
				tops[pos] = btop;
				sizes[pos] = req;
				used++;
				join_holes();
			end
		end
		total = '0;
		for (int i = 0; i < used; i++) begin
			total = total + sizes[i];
			if (total[16]) total = 17'hFFFF;
		end
		r.hole_count = used[5:0];
		r.free_total = total[15:0];
		return r;
	endfunction

	initial begin
		fails = 0;
		pending = 0;
		policy = PolicyFirst;
		pool = 16'(PoolReset);
		load_pool();
	end

	// Sample all three channels at the edge that accepts them
	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_addr == CfgPolicy) begin
					policy = cfg_data[1:0];
				end else begin
					pool = cfg_data;
					load_pool();
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(serve(s_axis_tdata[0], s_axis_tdata[16:1],
					s_axis_tdata[32:17]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[1:0];
				got.alloc_top = m_axis_tdata[17:2];
				got.hole_count = m_axis_tdata[23:18];
				got.free_total = m_axis_tdata[39:24];
				if (result_q.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					want = result_q.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fails++;
					end
					if (got.alloc_top !== want.alloc_top) begin
						$error("alloc_top: expected %0d, got %0d", want.alloc_top,
							got.alloc_top);
						fails++;
					end
					if (got.hole_count !== want.hole_count) begin
						$error("hole_count: expected %0d, got %0d", want.hole_count,
							got.hole_count);
						fails++;
					end
					if (got.free_total !== want.free_total) begin
						$error("free_total: expected %0d, got %0d", want.free_total,
							got.free_total);
						fails++;
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

>>> sim/testbench.sv
// Stimulus and verdict for the hole list allocator: directed and random
// allocate/free requests under several policies and pool sizes.
// Depends on hla_pkg, hole_list_allocator and hla_checker.
module testbench;
	import hla_pkg::*;

	localparam logic FuncAlloc = 1'b0;
	localparam logic FuncFree = 1'b1;
	localparam int CycleLimit = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_addr = CfgPolicy;
	logic [15:0] cfg_data = '0;
	int fails;
	int pending;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;
	logic [15:0] pool_now = 16'(PoolReset);

	// sizes of allocate requests in flight (0 for frees) and blocks held
	logic [15:0] req_sizes[$];
	logic [31:0] held_blocks[$];

	always #1 clk = ~clk;

	hole_list_allocator dut (.*);

	hla_checker u_check (.*);

	// Receiver: switches among always ready, random and long stalls
	always @(posedge clk) begin
		if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 1);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Record each block the allocator hands out so it can be freed later
	always @(posedge clk) begin
		logic [15:0] sz;
		if (m_axis_tvalid && m_axis_tready && req_sizes.size() > 0) begin
			sz = req_sizes.pop_front();
			if (sz != 0 && m_axis_tdata[1:0] == StatusOk)
				held_blocks.push_back({m_axis_tdata[17:2], sz});
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(logic func, logic [15:0] size, logic [15:0] btop, bit keep);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, btop, size, func};
		req_sizes.push_back(func == FuncAlloc ? size : 16'd0);
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0) burst_left--;
		if (!keep || burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			if (keep) repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
		end
	endtask

	// Register write once every outstanding result has come back
	task automatic write_reg(logic idx, logic [15:0] val);
		wait (pending == 0 && req_sizes.size() == 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CfgPool) begin
			pool_now = val;
			held_blocks.delete();
		end
	endtask

	task automatic random_phase(logic [1:0] pol, logic [15:0] psize, int n);
		int pick;
		logic [31:0] blk;
		logic [15:0] cap;
		write_reg(CfgPolicy, 16'(pol));
		write_reg(CfgPool, psize);
		cap = (pool_now > 16'd64) ? pool_now / 8 : ((pool_now == 0) ? 16'd1 : pool_now);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send(FuncAlloc, 16'($urandom_range(1, cap)), 16'($urandom), i < n - 1);
			end else if (pick < 85 && held_blocks.size() > 0) begin
				pick = $urandom_range(0, held_blocks.size() - 1);
				blk = held_blocks[pick];
				held_blocks.delete(pick);
				send(FuncFree, blk[15:0], blk[31:16], i < n - 1);
			end else if (pick < 92) begin
				send(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), i < n - 1);
			end else if (pick < 95) begin
				send(1'($urandom_range(0, 1)), 16'd0, 16'($urandom), i < n - 1);
			end else begin
				send(FuncFree, 16'($urandom_range(1, cap)), 16'($urandom_range(0, pool_now)),
					i < n - 1);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset pool, extremes, zero sizes, equal tops on free
		send(FuncAlloc, 16'd0, 16'hFFFF, 1'b1);
		send(FuncAlloc, 16'd100, 16'd0, 1'b1);
		send(FuncAlloc, 16'hFFFF, 16'd0, 1'b1);
		send(FuncFree, 16'd0, 16'd500, 1'b1);
		send(FuncFree, 16'd100, 16'd1024, 1'b1);
		send(FuncAlloc, 16'd1024, 16'd0, 1'b1);
		send(FuncAlloc, 16'd1, 16'd0, 1'b1);
		send(FuncFree, 16'd5, 16'd500, 1'b1);
		send(FuncFree, 16'd3, 16'd500, 1'b1);
		send(FuncFree, 16'd492, 16'd492, 1'b0);

		// Unknown policy picks nothing
		write_reg(CfgPolicy, 16'd3);
		send(FuncAlloc, 16'd1, 16'd0, 1'b1);
		send(FuncAlloc, 16'd0, 16'd0, 1'b0);

		// Zero pool leaves the table empty
		write_reg(CfgPolicy, 16'(PolicyBest));
		write_reg(CfgPool, 16'd0);
		send(FuncAlloc, 16'd1, 16'd0, 1'b1);
		send(FuncFree, 16'd7, 16'd7, 1'b0);

		// Largest pool: saturating merge, then fill the table past full
		write_reg(CfgPolicy, 16'(PolicyWorst));
		write_reg(CfgPool, 16'hFFFF);
		send(FuncFree, 16'hFFFF, 16'd0, 1'b1);
		send(FuncAlloc, 16'hFFFF, 16'd0, 1'b0);
		write_reg(CfgPolicy, 16'(PolicyFirst));
		write_reg(CfgPool, 16'hFFFF);
		send(FuncAlloc, 16'hFFFF, 16'd0, 1'b1);
		for (int k = 1; k <= MaxHoles + 1; k++)
			send(FuncFree, 16'd1, 16'(k * 10), k <= MaxHoles);

		// Random phases over several settings
		random_phase(PolicyFirst, 16'd1024, 120);
		random_phase(PolicyBest, 16'd4096, 120);
		random_phase(PolicyWorst, 16'hFFFF, 120);
		random_phase(2'd3, 16'd300, 60);
		random_phase(PolicyFirst, 16'd1, 60);
		random_phase(PolicyBest, 16'd200, 120);
		random_phase(PolicyWorst, 16'd777, 120);
		random_phase(PolicyFirst, 16'hFFFF, 120);

		wait (pending == 0 && req_sizes.size() == 0);
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/hla_pkg.sv
hdl/hla_cell.sv
hdl/hla_ctrl.sv
hdl/hole_list_allocator.sv
hdl/hla_checker.sv
sim/hla_checker.sv
sim/testbench.sv
